@@ sv/float32_restoring_divider_unit_assert.svh @@
// Assertion macros for the float32 restoring divider.
`ifndef FLOAT32_RESTORING_DIVIDER_UNIT_ASSERT_SVH
`define FLOAT32_RESTORING_DIVIDER_UNIT_ASSERT_SVH
// Implication checked on every clock, muted in reset.
`define FRD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, muted in reset.
`define FRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/frd_pkg.sv @@
// Package: constants and stage types for the float32 restoring divider.
`default_nettype none
package frd_pkg;
  localparam int NSTEP = 25;
  localparam logic [31:0] DIV0_POS = 32'h4F000000;
  localparam logic [31:0] DIV0_NEG = 32'h4F800000;
  localparam logic [31:0] INF_POS  = 32'h7F800000;
  localparam logic [31:0] INF_NEG  = 32'hFF800000;
  localparam logic [9:0]  EXP_BIAS = 10'd126;

  // Word carried down the cell chain.
  typedef struct packed {
    logic        sign;
    logic        zdvs;   // divisor magnitude zero
    logic        zdvd;   // dividend magnitude zero
    logic signed [9:0] expv;
    logic [25:0] rem;
    logic [23:0] dvs;
    logic [24:0] q;
  } stage_t;
endpackage
`default_nettype wire

@@ sv/frd_if.sv @@
// Valid/ready channel interfaces.
`default_nettype none
interface frd_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [31:0] dividend_bits;
  logic [31:0] divisor_bits;
  modport source (output valid, dividend_bits, divisor_bits, input ready);
  modport sink (input valid, dividend_bits, divisor_bits, output ready);
endinterface

interface frd_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [31:0] quotient_bits;
  logic overflow;
  modport source (output valid, quotient_bits, overflow, input ready);
  modport sink (input valid, quotient_bits, overflow, output ready);
endinterface
`default_nettype wire

@@ sv/frd_cell.sv @@
// One restoring-division cell: one quotient bit per cycle while en is high.
`default_nettype none
module frd_cell
  import frd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   vin,
  input  wire stage_t din,
  output logic        vout,
  output stage_t      dout
);
  stage_t nxt;
  logic   ge;
  always_comb begin
    nxt = din;
    ge = din.rem >= {2'b00, din.dvs};
    if (ge) begin
      nxt.rem = din.rem - {2'b00, din.dvs};
    end
    // quotient bits shift in from the bottom, MSB first
    nxt.q = {din.q[23:0], ge};
    nxt.rem = {nxt.rem[24:0], 1'b0};
  end
  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= vin;
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

@@ sv/frd_pack.sv @@
// Rounding, denormal shift and special-case packing.
`default_nettype none
module frd_pack
  import frd_pkg::*;
(
  input  wire stage_t    s,
  output logic [31:0]    qbits,
  output logic           ovf
);
  logic [5:0]  sh;
  logic [31:0] mant;
  logic signed [10:0] ef;
  logic [32:0] t;
  always_comb begin
    ovf = 1'b0;
    sh = '0;
    t = '0;
    if (s.expv < 0) begin
      if (s.expv < -10'sd30) mant = '0;
      else begin
        sh = 6'(1 - s.expv);
        t = {8'd0, s.q} + (33'd1 << (sh - 6'd1));
        mant = 32'(t >> sh);
      end
      ef = '0;
    end else begin
      ef = 11'(s.expv) + 11'sd1;
      mant = 32'(({7'd0, s.q} + 32'd1) >> 1);
    end
    mant = mant & 32'hFF7FFFFF;
    if (s.zdvs) qbits = s.sign ? DIV0_NEG : DIV0_POS;
    else if (s.zdvd) qbits = {s.sign, 31'd0};
    else if (ef < 11'sd255) qbits = {s.sign, 31'd0} | {1'b0, ef[7:0], 23'd0} | mant;
    else begin
      qbits = s.sign ? INF_NEG : INF_POS;
      ovf = 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ sv/float32_restoring_divider_unit.sv @@
// Top level: pipelined float32 restoring divider built from a cell chain.
// Stages from input accept to output valid: 1 setup stage,
//   25 division cells of one quotient bit each, 1 output register.
// Throughput: one word per cycle; the whole chain advances when the
//   output register is empty or being taken.
// Reset: rst (synchronous, high) clears all valid bits; payload not reset.
`default_nettype none
module float32_restoring_divider_unit
  import frd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  frd_in_if.sink    in_ch,
  frd_out_if.source out_ch
);
  `include "float32_restoring_divider_unit_assert.svh"

  // Chain advances whenever the output slot can take a word.
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Setup stage: sign, exponent, pre-normalized mantissas.
  stage_t s0;
  logic   v0;
  logic [23:0] ma, mb;
  logic signed [9:0] ed;
  always_comb begin
    ma = {1'b1, in_ch.dividend_bits[22:0]};
    mb = {1'b1, in_ch.divisor_bits[22:0]};
    ed = $signed({2'b00, in_ch.dividend_bits[30:23]})
       - $signed({2'b00, in_ch.divisor_bits[30:23]}) + $signed(EXP_BIAS);
  end
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_ch.valid;
    if (en) begin
      s0.sign <= in_ch.dividend_bits[31] ^ in_ch.divisor_bits[31];
      s0.zdvs <= in_ch.divisor_bits[30:0] == '0;
      s0.zdvd <= in_ch.dividend_bits[30:0] == '0;
      s0.dvs  <= mb;
      s0.q    <= '0;
      // Dividend below divisor: double it, lower the exponent.
      if (ma < mb) begin
        s0.rem  <= {1'b0, ma, 1'b0};
        s0.expv <= ed - 10'sd1;
      end else begin
        s0.rem  <= {2'b00, ma};
        s0.expv <= ed;
      end
    end
  end

  // Cell chain, MSB quotient bit first.
  stage_t sd [0:NSTEP];
  logic   vd [0:NSTEP];
  assign sd[0] = s0;
  assign vd[0] = v0;
  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    frd_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(vd[i]), .din(sd[i]), .vout(vd[i+1]), .dout(sd[i+1])
    );
  end

  logic [31:0] qb;
  logic        ov;
  frd_pack u_pack (.s(sd[NSTEP]), .qbits(qb), .ovf(ov));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= vd[NSTEP];
    if (en) begin
      out_ch.quotient_bits <= qb;
      out_ch.overflow      <= ov;
    end
  end

  `FRD_ASSERT_NEXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.quotient_bits), "stalled output changed")
  `FRD_ASSERT_IMP(a_ovf_inf, clk, rst, out_ch.valid && out_ch.overflow, out_ch.quotient_bits[30:0] == 31'h7F800000, "overflow without infinity")
  `FRD_ASSERT_IMP(a_ready, clk, rst, !out_ch.valid, in_ch.ready, "not ready with empty output")
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the float32 restoring divider: directed table plus random words, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import frd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  frd_in_if  in_ch (clk);
  frd_out_if out_ch (clk);

  float32_restoring_divider_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  typedef struct {
    logic [31:0] quotient_bits;
    logic        overflow;
  } quot_t;

  // Directed row: operands plus an optional typed-in expectation.
  typedef struct {
    logic [31:0] dvd;
    logic [31:0] dvs;
    bit          fixed;
    logic [31:0] q;
    logic        ovf;
  } row_t;

  quot_t quot_q[$];
  int    mismatches = 0;
  bit    send_done = 1'b0;
  bit    calm = 1'b0;       // last part of run: no idling on either side
  bit    hold_rx = 1'b0;    // long receiver hold-off for backpressure
  int    rows_left = 0;

  // Bit-exact quotient prediction.
  function automatic quot_t predict_quotient(logic [31:0] a, logic [31:0] b);
    quot_t       r;
    logic [31:0] sgn;
    int          ediff, e, sh, ef;
    logic [31:0] rem, dv, qb, q, mant;
    logic [63:0] t;
    sgn = (a ^ b) & 32'h80000000;
    ediff = int'(a[30:23]) - int'(b[30:23]);
    e = ediff + 126;
    r.overflow = 1'b0;
    if (b[30:0] == 31'd0) begin
      r.quotient_bits = sgn[31] ? DIV0_NEG : DIV0_POS;
    end else if (a[30:0] == 31'd0) begin
      r.quotient_bits = sgn;
    end else begin
      rem = {9'd0, 1'b1, a[22:0]};
      dv  = {9'd0, 1'b1, b[22:0]};
      qb = 32'h1000000;
      q = 0;
      if (rem < dv) begin
        rem = rem << 1;
        e = ediff + 125;
      end
      while (qb != 0) begin
        if (rem >= dv) begin
          q = q | qb;
          rem = rem - dv;
        end
        qb = qb >> 1;
        rem = rem << 1;
      end
      if (e < 0) begin
        sh = 1 - e;
        if (sh >= 32) begin
          mant = 0;
        end else begin
          t = 64'(q) + (64'd1 << (sh - 1));
          mant = 32'(t >> sh);
        end
        ef = 0;
      end else begin
        ef = e + 1;
        mant = (q + 32'd1) >> 1;
      end
      mant = mant & 32'hFF7FFFFF;
      if (ef < 255) begin
        r.quotient_bits = sgn | (32'(ef) << 23) | mant;
      end else begin
        r.quotient_bits = sgn[31] ? INF_NEG : INF_POS;
        r.overflow = 1'b1;
      end
    end
    return r;
  endfunction

  row_t rows[$];

  function automatic row_t mk(logic [31:0] a, logic [31:0] b, bit f = 0,
                              logic [31:0] q = 0, logic o = 0);
    row_t r;
    r.dvd = a; r.dvs = b; r.fixed = f; r.q = q; r.ovf = o;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:23] = 8'd0;                       // denormal-like
      1: v[30:23] = 8'hFF;                      // inf/NaN patterns
      2: v[30:0] = 31'd0;                       // signed zero
      3: v[30:23] = 8'($urandom_range(100, 154)); // typical range
      default: ;
    endcase
    return v;
  endfunction

  // Sender
  initial begin
    int   n;
    row_t r;
    in_ch.valid <= 1'b0;
    in_ch.dividend_bits <= '0;
    in_ch.divisor_bits <= '0;
    rows.push_back(mk(32'h3F800000, 32'h00000000, 1, DIV0_POS, 0)); // divide by zero +
    rows.push_back(mk(32'h3F800000, 32'h80000000, 1, DIV0_NEG, 0)); // divide by zero -
    rows.push_back(mk(32'h00000000, 32'h00000000, 1, DIV0_POS, 0)); // zero/zero: divisor first
    rows.push_back(mk(32'h80000000, 32'h3F800000, 1, 32'h80000000, 0)); // -0 dividend
    rows.push_back(mk(32'h00000000, 32'hBF800000, 1, 32'h80000000, 0));
    rows.push_back(mk(32'h7F7FFFFF, 32'h00800000, 1, INF_POS, 1)); // overflow
    rows.push_back(mk(32'hFF800000, 32'h3F800000, 1, INF_NEG, 1));
    rows.push_back(mk(32'h3F800000, 32'h3F800000));
    rows.push_back(mk(32'h40000000, 32'h3F800000));
    rows.push_back(mk(32'h3F800000, 32'h40400000));
    rows.push_back(mk(32'h00000001, 32'h7F7FFFFF)); // deep denormal, shift >= 32
    rows.push_back(mk(32'h00800000, 32'h3F800000)); // small exponent
    rows.push_back(mk(32'h00400000, 32'h3FFFFFFF)); // denormal operand
    rows.push_back(mk(32'h01000000, 32'h40000000));
    rows.push_back(mk(32'h3FFFFFFF, 32'h3F800001)); // rounding carry
    rows.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF)); // NaN patterns
    rows.push_back(mk(32'h7FC00000, 32'h00000001));
    rows.push_back(mk(32'h80000001, 32'h7F800000));
    rows.push_back(mk(32'h7F7FFFFF, 32'h3F000000));
    rows.push_back(mk(32'h3F000000, 32'h7F000000));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    n = rows.size() + 550;
    rows_left = rows.size();
    for (int i = 0; i < n; i++) begin
      if (i < rows.size()) r = rows[i];
      else r = mk(rand_operand(), rand_operand());
      if (i == n - 100) calm = 1'b1;
      if (i == 200) hold_rx = 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.dividend_bits <= r.dvd;
      in_ch.divisor_bits <= r.dvs;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      // accepted at this edge: queue its expectation
      if (r.fixed) begin
        quot_t e;
        e.quotient_bits = r.q;
        e.overflow = r.ovf;
        quot_q.push_back(e);
      end else begin
        quot_q.push_back(predict_quotient(r.dvd, r.dvs));
      end
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    wait (hold_rx);
    repeat (80) @(posedge clk);
    hold_rx = 1'b0;
  end

  // Receiver ready with random stall bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result check at each output handshake
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (quot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word q=%h ovf=%b", out_ch.quotient_bits, out_ch.overflow);
      end else begin
        quot_t e;
        e = quot_q.pop_front();
        if (e.quotient_bits !== out_ch.quotient_bits || e.overflow !== out_ch.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp q=%h ovf=%b got q=%h ovf=%b", e.quotient_bits,
                     e.overflow, out_ch.quotient_bits, out_ch.overflow);
        end
      end
    end
  end

  // Drain and report
  initial begin
    wait (send_done);
    while (quot_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

@@ float32_restoring_divider_unit.f @@
+incdir+sv
sv/frd_pkg.sv
sv/frd_if.sv
sv/frd_cell.sv
sv/frd_pack.sv
sv/float32_restoring_divider_unit.sv
dv/tb_top.sv
